// ===== sv/cdrm_pkg.sv =====
// Shared widths, types and helpers for the cluster density ratio unit.
package cdrm_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SIZE_W      = 4;
  localparam int SUM_W       = 20;
  localparam int CROSS_W     = 24;
  localparam int OFF_W       = 16;
  localparam int RATIO_W     = 28;
  localparam int BEST_W      = 27;
  localparam int MN_W        = 2 * SIZE_W;
  localparam int PAIRS_W     = 2 * SIZE_W;
  localparam int LR_W        = SUM_W + 1;
  localparam int PROD_W      = LR_W + MN_W;
  localparam int NUM_W       = PROD_W + FRAC_BITS;
  localparam int POS_W       = CROSS_W + 1;
  localparam int DEN_W       = PAIRS_W + POS_W;
  localparam int QUOT_W      = RATIO_W;
  localparam int MUL_STEPS   = MN_W;
  localparam int STEP_CW     = $clog2(MUL_STEPS);
  localparam int DIV_CW      = $clog2(QUOT_W);
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 56;

  localparam logic [OFF_W-1:0] OFFSET_RESET = OFF_W'(655);
  localparam logic [RATIO_W-1:0] RATIO_MAX_POS = RATIO_W'((64'd1 << (RATIO_W - 1)) - 64'd1);
  localparam logic [RATIO_W-1:0] RATIO_MIN_MAG = RATIO_W'(64'd1 << (RATIO_W - 1));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_PREP,
    ST_MUL2,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  function automatic logic [PAIRS_W-1:0] pair_count(input logic [SIZE_W-1:0] k);
    logic [MN_W-1:0] p;
    p = MN_W'(k) * MN_W'(k - 1'b1);
    return PAIRS_W'(p >> 1);
  endfunction

endpackage

// ===== sv/cluster_density_ratio_max_unit.sv =====
// Cluster density ratio unit with running maximum: top level.
//
// One record enters on the in_ stream: group sizes, weight sums L, R, C and
// a clear flag for the running maximum. One result leaves on the out_ stream
// for each record: the signed Q11.16 ratio, the running maximum and a
// saturation flag. cfg_wr_en writes the inter density offset (Q0.16).
// The divider is skipped when the denominator is zero, and it stops before
// the first divide step when the quotient is already out of range. The
// work is two 8-step shift-add multiplies (one bit of the small
// multiplier per cycle) and a restoring divider that forms one quotient
// bit per cycle over 28 bits.
// One record is processed at a time; in_tready is high while the unit is
// idle, so a new record is taken only after the last result is loaded.
// The result sits in an output register, so the next record
// is taken while a result still waits. If the receiver stalls, the unit
// holds its finished result and waits before loading the next one.
// Reset clears the running maximum, sets the offset to 655 and empties the
// output register.
module cluster_density_ratio_max_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // size_left[3:0], size_right[7:4], sum_left[27:8], sum_right[47:28],
  // sum_cross[71:48], clear_max[72], zero fill above
  input  logic [cdrm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // ratio[27:0], ratio_max[54:28], saturated[55]
  output logic [cdrm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [cdrm_pkg::OFF_W-1:0]       cfg_wr_data
);

  logic [cdrm_pkg::SIZE_W-1:0]  size_left;
  logic [cdrm_pkg::SIZE_W-1:0]  size_right;
  logic [cdrm_pkg::SUM_W-1:0]   sum_left;
  logic [cdrm_pkg::SUM_W-1:0]   sum_right;
  logic [cdrm_pkg::CROSS_W-1:0] sum_cross;
  logic                         clear_max;

  assign size_left  = in_tdata[3:0];
  assign size_right = in_tdata[7:4];
  assign sum_left   = in_tdata[27:8];
  assign sum_right  = in_tdata[47:28];
  assign sum_cross  = in_tdata[71:48];
  assign clear_max  = in_tdata[72];

  cdrm_pkg::state_t state_r, state_nxt;

  logic [cdrm_pkg::OFF_W-1:0]    offset_r;
  logic [cdrm_pkg::BEST_W-1:0]   best_r;
  logic                          out_valid_r;
  logic [cdrm_pkg::RATIO_W-1:0]  ratio_r;
  logic [cdrm_pkg::BEST_W-1:0]   ratio_max_r;
  logic                          sat_r;

  logic [cdrm_pkg::LR_W-1:0]     lr_r;
  logic [cdrm_pkg::PAIRS_W-1:0]  pairs_r;
  logic                          clr_r;
  logic [cdrm_pkg::DEN_W-1:0]    mcand_r;
  logic [cdrm_pkg::DEN_W-1:0]    acc_r;
  logic [cdrm_pkg::MN_W-1:0]     mplier_r;
  logic [cdrm_pkg::POS_W-1:0]    offc_r;
  logic [cdrm_pkg::POS_W-1:0]    pos_r;
  logic [cdrm_pkg::PROD_W-1:0]   prod_r;
  logic                          neg_r;
  logic [cdrm_pkg::STEP_CW-1:0]  cnt_r;

  logic                          accept;
  logic                          load_out;
  logic                          div_start;
  logic                          den_zero;
  logic                          last_step;
  cdrm_pkg::div_res_t            div_res;

  logic [cdrm_pkg::LR_W-1:0]     lr_in;
  logic [cdrm_pkg::MN_W-1:0]     mn_in;
  logic [cdrm_pkg::PAIRS_W-1:0]  pairs_in;
  logic                          neg_now;
  logic [cdrm_pkg::POS_W-1:0]    dmag;
  logic [cdrm_pkg::RATIO_W-1:0]  ratio_nxt;
  logic                          sat_nxt;
  logic [cdrm_pkg::BEST_W-1:0]   posval;
  logic [cdrm_pkg::BEST_W-1:0]   best_base;
  logic [cdrm_pkg::RATIO_W-1:0]  mag;

  assign lr_in    = cdrm_pkg::LR_W'(sum_left) + cdrm_pkg::LR_W'(sum_right);
  assign mn_in    = cdrm_pkg::MN_W'(size_left) * cdrm_pkg::MN_W'(size_right);
  assign pairs_in = cdrm_pkg::pair_count(size_left) + cdrm_pkg::pair_count(size_right);

  assign neg_now  = pos_r < cdrm_pkg::POS_W'(lr_r);
  assign dmag     = neg_now ? (cdrm_pkg::POS_W'(lr_r) - pos_r)
                            : (pos_r - cdrm_pkg::POS_W'(lr_r));
  assign den_zero = (acc_r == '0);
  assign last_step = (cnt_r == cdrm_pkg::STEP_CW'(cdrm_pkg::MUL_STEPS - 1));

  cdrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({prod_r, {cdrm_pkg::FRAC_BITS{1'b0}}}),
    .den   (acc_r),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdrm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    accept    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      cdrm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          accept    = 1'b1;
          state_nxt = cdrm_pkg::ST_MUL1;
        end
      end
      cdrm_pkg::ST_MUL1: begin
        if (last_step) begin
          state_nxt = cdrm_pkg::ST_PREP;
        end
      end
      cdrm_pkg::ST_PREP: begin
        state_nxt = cdrm_pkg::ST_MUL2;
      end
      cdrm_pkg::ST_MUL2: begin
        if (last_step) begin
          state_nxt = cdrm_pkg::ST_CHECK;
        end
      end
      cdrm_pkg::ST_CHECK: begin
        if (den_zero) begin
          state_nxt = cdrm_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = cdrm_pkg::ST_DIV;
        end
      end
      cdrm_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_nxt = cdrm_pkg::ST_DONE;
        end
      end
      cdrm_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = cdrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cdrm_pkg::ST_IDLE;
      end
    endcase
  end

  // result formatting and saturation
  always_comb begin
    ratio_nxt = '0;
    sat_nxt   = 1'b0;
    mag       = div_res.quot;
    if (den_zero) begin
      sat_nxt   = 1'b1;
      ratio_nxt = (prod_r != '0) ? cdrm_pkg::RATIO_MAX_POS : '0;
    end else if (!neg_r) begin
      if (div_res.ovf || div_res.quot[cdrm_pkg::QUOT_W-1]) begin
        sat_nxt   = 1'b1;
        ratio_nxt = cdrm_pkg::RATIO_MAX_POS;
      end else begin
        ratio_nxt = div_res.quot;
      end
    end else begin
      if (div_res.ovf || (div_res.quot > cdrm_pkg::RATIO_MIN_MAG)) begin
        sat_nxt = 1'b1;
        mag     = cdrm_pkg::RATIO_MIN_MAG;
      end
      ratio_nxt = '0 - mag;
    end
    posval    = (den_zero || !neg_r) ? ratio_nxt[cdrm_pkg::BEST_W-1:0] : '0;
    best_base = clr_r ? '0 : best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= cdrm_pkg::OFFSET_RESET;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        best_r      <= (posval > best_base) ? posval : best_base;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ratio_r     <= ratio_nxt;
      ratio_max_r <= (posval > best_base) ? posval : best_base;
      sat_r       <= sat_nxt;
    end
  end

  // shift-add datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      cdrm_pkg::ST_IDLE: begin
        if (accept) begin
          lr_r     <= lr_in;
          pairs_r  <= pairs_in;
          clr_r    <= clear_max;
          mcand_r  <= cdrm_pkg::DEN_W'(lr_in);
          acc_r    <= '0;
          mplier_r <= mn_in;
          offc_r   <= cdrm_pkg::POS_W'(offset_r);
          pos_r    <= cdrm_pkg::POS_W'(sum_cross);
          cnt_r    <= '0;
        end
      end
      cdrm_pkg::ST_MUL1: begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
          pos_r <= pos_r + offc_r;
        end
        mcand_r  <= mcand_r << 1;
        offc_r   <= offc_r << 1;
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r + 1'b1;
      end
      cdrm_pkg::ST_PREP: begin
        prod_r   <= acc_r[cdrm_pkg::PROD_W-1:0];
        neg_r    <= neg_now;
        mcand_r  <= cdrm_pkg::DEN_W'(dmag);
        acc_r    <= '0;
        mplier_r <= pairs_r;
        cnt_r    <= '0;
      end
      cdrm_pkg::ST_MUL2: begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {sat_r, ratio_max_r, ratio_r};

endmodule

// ===== sv/cdrm_div.sv =====
// Bit-serial restoring divider with range check on the quotient.
module cdrm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cdrm_pkg::NUM_W-1:0] num,
  input  logic [cdrm_pkg::DEN_W-1:0] den,
  output cdrm_pkg::div_res_t         res
);

  logic                         busy_r;
  logic                         done_r;
  logic                         ovf_r;
  logic [cdrm_pkg::DIV_CW-1:0]  cnt_r;
  logic [cdrm_pkg::DEN_W-1:0]   rem_r;
  logic [cdrm_pkg::DEN_W-1:0]   den_r;
  logic [cdrm_pkg::QUOT_W-1:0]  numlo_r;
  logic [cdrm_pkg::QUOT_W-1:0]  quot_r;

  logic [cdrm_pkg::DEN_W-1:0]   num_hi;
  logic [cdrm_pkg::DEN_W:0]     shifted;
  logic [cdrm_pkg::DEN_W:0]     diff;

  assign num_hi  = cdrm_pkg::DEN_W'(num[cdrm_pkg::NUM_W-1:cdrm_pkg::QUOT_W]);
  assign shifted = {rem_r, numlo_r[cdrm_pkg::QUOT_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (num_hi >= den) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == cdrm_pkg::DIV_CW'(cdrm_pkg::QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf_r   <= (num_hi >= den);
      rem_r   <= num_hi;
      den_r   <= den;
      numlo_r <= num[cdrm_pkg::QUOT_W-1:0];
      quot_r  <= '0;
    end else if (busy_r) begin
      numlo_r <= numlo_r << 1;
      if (!diff[cdrm_pkg::DEN_W]) begin
        rem_r  <= diff[cdrm_pkg::DEN_W-1:0];
        quot_r <= {quot_r[cdrm_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= shifted[cdrm_pkg::DEN_W-1:0];
        quot_r <= {quot_r[cdrm_pkg::QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = quot_r;

endmodule

// ===== dv/tb_cluster_density_ratio_max_unit.sv =====
// Testbench for cluster_density_ratio_max_unit: directed and random records, scoreboard check.
`timescale 1ns / 1ps

module tb_cluster_density_ratio_max_unit;

  typedef struct packed {
    logic [6:0]                   fill;
    logic                         clear_max;
    logic [cdrm_pkg::CROSS_W-1:0] sum_cross;
    logic [cdrm_pkg::SUM_W-1:0]   sum_right;
    logic [cdrm_pkg::SUM_W-1:0]   sum_left;
    logic [cdrm_pkg::SIZE_W-1:0]  size_right;
    logic [cdrm_pkg::SIZE_W-1:0]  size_left;
  } record_t;

  typedef struct packed {
    logic                                saturated;
    logic [cdrm_pkg::BEST_W-1:0]         ratio_max;
    logic signed [cdrm_pkg::RATIO_W-1:0] ratio;
  } density_t;

  class ratio_scoreboard;
    logic [cdrm_pkg::OFF_W-1:0]  offset;
    logic [cdrm_pkg::BEST_W-1:0] best;
    density_t                    pending[$];
    int                          errors;
    int                          checked;
    int                          n_sat;
    int                          n_neg;
    int                          n_clear;

    function new();
      offset = cdrm_pkg::OFFSET_RESET;
      best   = '0;
    endfunction

    // Exact rational quotient, truncated toward zero, clamped to the ratio range.
    function void note_input(record_t r);
      bit [63:0] m, n, mn, pairs, num, pos, lr, dmag, den, q;
      bit        neg;
      density_t  d;
      logic [cdrm_pkg::RATIO_W-1:0] posval;
      m      = 64'(r.size_left);
      n      = 64'(r.size_right);
      mn     = m * n;
      pairs  = (m * (m - 1)) / 2 + (n * (n - 1)) / 2;
      lr     = 64'(r.sum_left) + 64'(r.sum_right);
      num    = (lr * mn) << cdrm_pkg::FRAC_BITS;
      pos    = 64'(r.sum_cross) + 64'(offset) * mn;
      neg    = pos < lr;
      dmag   = neg ? lr - pos : pos - lr;
      den    = pairs * dmag;
      posval = '0;
      d.saturated = 1'b0;
      if (r.clear_max) begin
        best = '0;
        n_clear++;
      end
      if (den == 0) begin
        d.saturated = 1'b1;
        posval      = (num != 0) ? cdrm_pkg::RATIO_MAX_POS : '0;
        d.ratio     = posval;
      end else begin
        q = num / den;
        if (!neg) begin
          if (q > 64'(cdrm_pkg::RATIO_MAX_POS)) begin
            q           = 64'(cdrm_pkg::RATIO_MAX_POS);
            d.saturated = 1'b1;
          end
          posval  = cdrm_pkg::RATIO_W'(q);
          d.ratio = posval;
        end else begin
          if (q > 64'(cdrm_pkg::RATIO_MIN_MAG)) begin
            q           = 64'(cdrm_pkg::RATIO_MIN_MAG);
            d.saturated = 1'b1;
          end
          d.ratio = cdrm_pkg::RATIO_W'(64'd0 - q);
        end
      end
      if (posval > cdrm_pkg::RATIO_W'(best)) best = posval[cdrm_pkg::BEST_W-1:0];
      d.ratio_max = best;
      pending.push_back(d);
    endfunction

    function void check_result(logic [cdrm_pkg::OUT_TDATA_W-1:0] data);
      density_t got, want;
      got = data;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, got ratio %0d max %0d sat %0b",
                 $time, got.ratio, got.ratio_max, got.saturated);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.saturated) n_sat++;
      if (want.ratio < 0) n_neg++;
      if (got.ratio !== want.ratio) begin
        $display("%0t: ratio expected %0d got %0d", $time, want.ratio, got.ratio);
        errors++;
      end
      if (got.ratio_max !== want.ratio_max) begin
        $display("%0t: ratio_max expected %0d got %0d", $time, want.ratio_max,
                 got.ratio_max);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0b got %0b", $time, want.saturated,
                 got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n       = 1'b0;
  logic                             in_tvalid   = 1'b0;
  logic                             in_tready;
  logic [cdrm_pkg::IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                             out_tvalid;
  logic                             out_tready  = 1'b0;
  logic [cdrm_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_wr_en   = 1'b0;
  logic [cdrm_pkg::OFF_W-1:0]       cfg_wr_data = '0;

  int              send_idle_pct = 0;
  int              stall_pct     = 0;
  ratio_scoreboard sb;

  cluster_density_ratio_max_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Result is checked before the same-edge input is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.offset = cfg_wr_data;
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.note_input(record_t'(in_tdata));
    end
  end

  task automatic push_record(input record_t r);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_and_write(input logic [cdrm_pkg::OFF_W-1:0] value);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic record_t make_record(input int unsigned sl, input int unsigned sr,
                                          input int unsigned l, input int unsigned r,
                                          input int unsigned c, input bit clr);
    record_t rec;
    rec            = '0;
    rec.size_left  = cdrm_pkg::SIZE_W'(sl);
    rec.size_right = cdrm_pkg::SIZE_W'(sr);
    rec.sum_left   = cdrm_pkg::SUM_W'(l);
    rec.sum_right  = cdrm_pkg::SUM_W'(r);
    rec.sum_cross  = cdrm_pkg::CROSS_W'(c);
    rec.clear_max  = clr;
    return rec;
  endfunction

  // Mostly in-range records with the cross sum placed around L+R.
  function automatic record_t random_record();
    int unsigned sl, sr, l, r, kind;
    longint      c, lr, shift;
    if ($urandom_range(99) < 85) begin
      sl = $urandom_range(2, 12);
      sr = $urandom_range(2, 12);
    end else begin
      sl = $urandom_range(0, 15);
      sr = $urandom_range(0, 15);
    end
    if ($urandom_range(99) < 10) begin
      l = $urandom & 32'hFFFFF;
      r = $urandom & 32'hFFFFF;
    end else if ($urandom_range(99) < 5) begin
      l = 0;
      r = 0;
    end else begin
      l = $urandom_range(0, 786432);
      r = $urandom_range(0, 786432);
    end
    lr    = longint'(l) + longint'(r);
    shift = longint'(sb.offset) * sl * sr;
    kind  = $urandom_range(99);
    if (kind < 50)      c = lr + $urandom_range(0, 1 << 20);
    else if (kind < 65) c = $urandom & 32'hFFFFFF;
    else if (kind < 75) c = lr - $urandom_range(0, 1 << 20);
    else if (kind < 85) c = lr - shift + longint'($urandom_range(0, 6)) - 3;
    else                c = lr + longint'($urandom_range(0, 64)) - 32;
    if (c < 0) c = 0;
    if (c > 64'hFFFFFF) c = 64'hFFFFFF;
    return make_record(sl, sr, l, r, int'(c), ($urandom_range(99) < 10));
  endfunction

  task automatic random_phase(input logic [cdrm_pkg::OFF_W-1:0] value, input int send_pct,
                              input int stall, input int count);
    drain_and_write(value);
    send_idle_pct = send_pct;
    stall_pct     = stall;
    repeat (count) push_record(random_record());
  endtask

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed records at the reset offset.
    push_record(make_record(2, 2, 0, 0, 0, 0));
    push_record(make_record(12, 12, 786432, 786432, 9437184, 0));
    push_record(make_record(2, 12, 65536, 65536, 1 << 20, 0));
    push_record(make_record(3, 4, 500000, 500000, 1000, 0));
    push_record(make_record(1, 1, 100, 0, 5000, 0));
    push_record(make_record(0, 5, 100, 0, 7000, 0));
    push_record(make_record(2, 2, 10000, 10000, 20000 - 655 * 4, 0));
    push_record(make_record(12, 12, 786432, 786432, 2 * 786432 - 655 * 144 + 1, 0));
    push_record(make_record(12, 12, 786432, 786432, 2 * 786432 - 655 * 144 - 1, 0));
    push_record(make_record(15, 15, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF, 1));
    push_record(make_record(4, 5, 30000, 20000, 900000, 1));
    push_record(make_record(13, 14, 400000, 300000, 24'h800000, 0));
    push_record(make_record(0, 0, 0, 0, 0, 0));
    push_record(make_record(6, 7, 700000, 600000, 12345, 1));
    push_record(make_record(12, 2, 0, 786432, 0, 0));
    push_record(make_record(1, 0, 20'hFFFFF, 0, 24'hFFFFFF, 0));
    push_record(make_record(8, 3, 123456, 654321, 3000000, 0));

    random_phase(16'd0, 0, 0, 150);
    random_phase(16'hFFFF, 69, 0, 150);
    random_phase(cdrm_pkg::OFF_W'($urandom_range(1, 65534)), 0, 69, 150);
    random_phase(cdrm_pkg::OFFSET_RESET, 25, 25, 150);
    random_phase(cdrm_pkg::OFF_W'($urandom_range(1, 4000)), 0, 0, 150);

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Checked %0d results across five offset settings and four idle patterns,",
             sb.checked);
    $display("%0d saturated, %0d negative, %0d running-max clears.",
             sb.n_sat, sb.n_neg, sb.n_clear);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cdrm_pkg.sv
sv/cdrm_div.sv
sv/cluster_density_ratio_max_unit.sv
dv/tb_cluster_density_ratio_max_unit.sv
